[rtl/core/smie_pkg.sv]
// Shared types, opcode codes and sequencer states for the stack machine executor.
// Depends on nothing; smie_divider, smie_alu and the top level refer to it by scoped names.
`default_nettype none
package smie_pkg;

    localparam int unsigned MEM_WORDS_DEFAULT = 16384;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_EXEC  = 2'd1,
        FUNC_SETPC = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_ADDR = 6'd2;
    localparam logic [5:0] OP_JMP  = 6'd3;
    localparam logic [5:0] OP_JSR  = 6'd4;
    localparam logic [5:0] OP_BZ   = 6'd5;
    localparam logic [5:0] OP_BNZ  = 6'd6;
    localparam logic [5:0] OP_ENT  = 6'd7;
    localparam logic [5:0] OP_ADJ  = 6'd8;
    localparam logic [5:0] OP_LEV  = 6'd9;
    localparam logic [5:0] OP_LI   = 6'd10;
    localparam logic [5:0] OP_LC   = 6'd11;
    localparam logic [5:0] OP_SI   = 6'd12;
    localparam logic [5:0] OP_SC   = 6'd13;
    localparam logic [5:0] OP_PSH  = 6'd14;
    localparam logic [5:0] OP_OR   = 6'd15;
    localparam logic [5:0] OP_XOR  = 6'd16;
    localparam logic [5:0] OP_AND  = 6'd17;
    localparam logic [5:0] OP_EQ   = 6'd18;
    localparam logic [5:0] OP_NE   = 6'd19;
    localparam logic [5:0] OP_LT   = 6'd20;
    localparam logic [5:0] OP_GT   = 6'd21;
    localparam logic [5:0] OP_LE   = 6'd22;
    localparam logic [5:0] OP_GE   = 6'd23;
    localparam logic [5:0] OP_SHL  = 6'd24;
    localparam logic [5:0] OP_SHR  = 6'd25;
    localparam logic [5:0] OP_ADD  = 6'd26;
    localparam logic [5:0] OP_SUB  = 6'd27;
    localparam logic [5:0] OP_MUL  = 6'd28;
    localparam logic [5:0] OP_DIV  = 6'd29;
    localparam logic [5:0] OP_MOD  = 6'd30;
    localparam logic [5:0] OP_EXIT = 6'd31;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_EXITED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,      // first memory read issued
        S_RD1W,     // first read data available
        S_RD2W,     // second read data available
        S_DIV,      // divider running
        S_DONE      // result ready to go out
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

endpackage
`default_nettype wire

[rtl/core/smie_divider.sv]
// Radix-2 restoring divider on unsigned 32-bit magnitudes, one quotient bit per cycle.
// Depends on smie_pkg for the request and response structs.
`default_nettype none
module smie_divider (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  smie_pkg::div_req_t  req,
    output smie_pkg::div_rsp_t  rsp
);
    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[31]} - {1'b0, dvs_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[30:0], quot_reg[31]};
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without run");
    a_cnt_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && !req.start) |=> !busy_reg) else $error("divider started itself");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held");
`endif
endmodule
`default_nettype wire

[rtl/core/smie_data_mem.sv]
// Word-wide data memory with one registered read port and one write port.
// Depends on nothing beyond its parameter.
`default_nettype none
module smie_data_mem #(
    parameter int unsigned MEM_WORDS = 16384,
    localparam int unsigned AW = $clog2(MEM_WORDS)
) (
    input  wire          aclk,
    input  wire          we,
    input  wire [AW-1:0] waddr,
    input  wire [31:0]   wdata,
    input  wire [AW-1:0] raddr,
    output logic [31:0]  rdata
);
    logic [31:0] mem [MEM_WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/core/smie_alu.sv]
// Shared combinational unit for logic, compare, shift, add, subtract and multiply.
// Depends on smie_pkg for opcode codes.
`default_nettype none
module smie_alu (
    input  wire  [5:0]  op,
    input  wire  [31:0] l,
    input  wire  [31:0] r,
    output logic [31:0] y
);
    logic slt_lr, slt_rl;
    logic [4:0] sh;

    always_comb begin
        slt_lr = $signed(l) < $signed(r);
        slt_rl = $signed(r) < $signed(l);
        sh     = r[4:0];
        unique case (op)
            smie_pkg::OP_OR:  y = l | r;
            smie_pkg::OP_XOR: y = l ^ r;
            smie_pkg::OP_AND: y = l & r;
            smie_pkg::OP_EQ:  y = {31'd0, l == r};
            smie_pkg::OP_NE:  y = {31'd0, l != r};
            smie_pkg::OP_LT:  y = {31'd0, slt_lr};
            smie_pkg::OP_GT:  y = {31'd0, slt_rl};
            smie_pkg::OP_LE:  y = {31'd0, !slt_rl};
            smie_pkg::OP_GE:  y = {31'd0, !slt_lr};
            smie_pkg::OP_SHL: y = l << sh;
            smie_pkg::OP_SHR: y = $unsigned($signed(l) >>> sh);
            smie_pkg::OP_ADD: y = l + r;
            smie_pkg::OP_SUB: y = l - r;
            smie_pkg::OP_MUL: y = l * r;
            default:          y = l;
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/stack_machine_instruction_executor_top.sv]
// Top level of the stack machine instruction executor: sequencer, memory, ALU, divider.
// Depends on smie_pkg, smie_data_mem, smie_alu and smie_divider.
`default_nettype none
// Each input word either writes a data memory word, executes one instruction,
// loads the pc and the stack and frame pointers, or does nothing (FUNC_NOP);
// each gives exactly one result word. The block is not ready while it works
// on a word. A write, pointer load or instruction without memory access goes
// straight to the result state; one with a memory read passes through the
// read states, LEV and SC with two reads through the one registered read port,
// and DIV and MOD then wait on the bit-serial divider unless the divisor is
// zero. The result is held in an output register until taken. Data memory is
// undefined until written; reading a never-written word gives an unspecified
// value.
module stack_machine_instruction_executor_top #(
    parameter int unsigned MEM_WORDS = smie_pkg::MEM_WORDS_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: opcode[5:0], operand[37:6], address[53:38],
    // stack_start[69:54], zero fill to 72 bits.
    input  wire  [71:0] s_tdata,
    // s_tuser: func[1:0].
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata, low bit up: next_pc[31:0], acc_value[63:32], exit_value[95:64],
    // cycle_count[127:96].
    output logic [127:0] m_tdata,
    // m_tuser: status[1:0].
    output logic [1:0]  m_tuser
);
    localparam int unsigned AW = $clog2(MEM_WORDS);

    smie_pkg::state_t state_reg, state_next;

    logic [31:0] acc_reg, acc_next;
    logic [31:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] fp_reg, fp_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] exitv_reg, exitv_next;
    logic [31:0] tmp_reg, tmp_next;     // first popped word
    logic [5:0]  op_reg;

    // Memory ports.
    logic          we;
    logic [31:0]   wbyte, wdata;
    logic [31:0]   rbyte;
    logic [31:0]   rdata;
    logic          w_in, r_in;

    assign w_in = (wbyte[31:2] < 30'(MEM_WORDS));
    assign r_in = (rbyte[31:2] < 30'(MEM_WORDS));

    logic          rin1_reg, rin1_next; // read address in range

    smie_data_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .aclk (aclk),
        .we   (we && w_in),
        .waddr(wbyte[AW+1:2]),
        .wdata(wdata),
        .raddr(rbyte[AW+1:2]),
        .rdata(rdata)
    );

    logic [31:0] rd;
    assign rd = rin1_reg ? rdata : 32'd0;

    logic [31:0] alu_y;
    smie_alu u_alu (.op(op_reg), .l(rd), .r(acc_reg), .y(alu_y));

    smie_pkg::div_req_t dreq;
    smie_pkg::div_rsp_t drsp;
    smie_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic        lneg_reg, lneg_next;
    logic        rneg_reg, rneg_next;

    // Input fields.
    logic [1:0]  in_func;
    logic [5:0]  in_op;
    logic [31:0] in_imm;
    logic [15:0] in_addr, in_ss;
    assign in_func = s_tuser;
    assign in_op   = s_tdata[5:0];
    assign in_imm  = s_tdata[37:6];
    assign in_addr = s_tdata[53:38];
    assign in_ss   = s_tdata[69:54];

    logic acc_in;
    assign acc_in = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smie_pkg::S_IDLE: if (acc_in) begin
                if (in_func == smie_pkg::FUNC_EXEC &&
                    (in_op == smie_pkg::OP_LEV || in_op == smie_pkg::OP_LI ||
                     in_op == smie_pkg::OP_LC || in_op == smie_pkg::OP_SI ||
                     in_op == smie_pkg::OP_SC || in_op == smie_pkg::OP_EXIT ||
                     (in_op >= smie_pkg::OP_OR && in_op <= smie_pkg::OP_MOD)))
                    state_next = smie_pkg::S_RD1;
                else
                    state_next = smie_pkg::S_DONE;
            end
            smie_pkg::S_RD1: state_next = smie_pkg::S_RD1W;
            smie_pkg::S_RD1W: begin
                if (op_reg == smie_pkg::OP_LEV || op_reg == smie_pkg::OP_SC)
                    state_next = smie_pkg::S_RD2W;
                else if ((op_reg == smie_pkg::OP_DIV || op_reg == smie_pkg::OP_MOD)
                         && acc_reg != 32'd0)
                    state_next = smie_pkg::S_DIV;
                else
                    state_next = smie_pkg::S_DONE;
            end
            smie_pkg::S_RD2W: state_next = smie_pkg::S_DONE;
            smie_pkg::S_DIV: if (drsp.done) state_next = smie_pkg::S_DONE;
            smie_pkg::S_DONE: if (m_tready) state_next = smie_pkg::S_IDLE;
            default: state_next = smie_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        acc_next    = acc_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        fp_next     = fp_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        exitv_next  = exitv_reg;
        tmp_next    = tmp_reg;
        lneg_next   = lneg_reg;
        rneg_next   = rneg_reg;
        rin1_next   = r_in;
        we          = 1'b0;
        wbyte       = 32'd0;
        wdata       = 32'd0;
        rbyte       = {16'd0, sp_reg};
        dreq.start    = 1'b0;
        dreq.dividend = rd[31] ? 32'd0 - rd : rd;
        dreq.divisor  = acc_reg[31] ? 32'd0 - acc_reg : acc_reg;
        s_tready    = (state_reg == smie_pkg::S_IDLE);
        unique case (state_reg)
            smie_pkg::S_IDLE: if (acc_in) begin
                status_next = smie_pkg::ST_RUN;
                exitv_next  = 32'd0;
                unique case (in_func)
                    smie_pkg::FUNC_WRITE: begin
                        we = 1'b1; wbyte = {16'd0, in_addr}; wdata = in_imm;
                    end
                    smie_pkg::FUNC_SETPC: begin
                        pc_next = {16'd0, in_addr};
                        sp_next = in_ss; fp_next = in_ss; cnt_next = 32'd0;
                    end
                    smie_pkg::FUNC_EXEC: begin
                        cnt_next = cnt_reg + 32'd1;
                        pc_next  = pc_reg + 32'd1;
                        priority if (in_op == smie_pkg::OP_LEA) begin
                            acc_next = {16'd0, fp_reg} + (in_imm << 2);
                            pc_next  = pc_reg + 32'd2;
                        end else if (in_op == smie_pkg::OP_IMM ||
                                     in_op == smie_pkg::OP_ADDR) begin
                            acc_next = in_imm; pc_next = pc_reg + 32'd2;
                        end else if (in_op == smie_pkg::OP_JMP) begin
                            pc_next = in_imm;
                        end else if (in_op == smie_pkg::OP_JSR) begin
                            sp_next = sp_reg - 16'd4;
                            we = 1'b1; wbyte = {16'd0, sp_next}; wdata = pc_reg + 32'd2;
                            pc_next = in_imm;
                        end else if (in_op == smie_pkg::OP_BZ) begin
                            pc_next = (acc_reg != 32'd0) ? pc_reg + 32'd2 : in_imm;
                        end else if (in_op == smie_pkg::OP_BNZ) begin
                            pc_next = (acc_reg != 32'd0) ? in_imm : pc_reg + 32'd2;
                        end else if (in_op == smie_pkg::OP_ENT) begin
                            sp_next = sp_reg - 16'd4;
                            we = 1'b1; wbyte = {16'd0, sp_next}; wdata = {16'd0, fp_reg};
                            fp_next = sp_next;
                            sp_next = sp_next - 16'(in_imm << 2);
                            pc_next = pc_reg + 32'd2;
                        end else if (in_op == smie_pkg::OP_ADJ) begin
                            sp_next = sp_reg + 16'(in_imm << 2);
                            pc_next = pc_reg + 32'd2;
                        end else if (in_op == smie_pkg::OP_PSH) begin
                            sp_next = sp_reg - 16'd4;
                            we = 1'b1; wbyte = {16'd0, sp_next}; wdata = acc_reg;
                        end else if (in_op > smie_pkg::OP_EXIT) begin
                            status_next = smie_pkg::ST_UNKNOWN;
                            pc_next = pc_reg;
                        end else begin
                            pc_next = pc_reg; // settled in later states
                        end
                    end
                    default: ;
                endcase
            end
            smie_pkg::S_RD1: begin
                // Issue the first read.
                if (op_reg == smie_pkg::OP_LI || op_reg == smie_pkg::OP_LC)
                    rbyte = acc_reg;
                else if (op_reg == smie_pkg::OP_LEV)
                    rbyte = {16'd0, fp_reg};
                else
                    rbyte = {16'd0, sp_reg};
                rin1_next = r_in;
                if (op_reg == smie_pkg::OP_LEV)
                    sp_next = fp_reg + 16'd4;
                else if (op_reg != smie_pkg::OP_EXIT && op_reg != smie_pkg::OP_LI &&
                         op_reg != smie_pkg::OP_LC)
                    sp_next = sp_reg + 16'd4;
            end
            smie_pkg::S_RD1W: begin
                tmp_next = rd;
                pc_next  = pc_reg + 32'd1;
                lneg_next = rd[31];
                rneg_next = acc_reg[31];
                unique case (op_reg)
                    smie_pkg::OP_LEV: begin
                        fp_next = rd[15:0];
                        rbyte = {16'd0, sp_reg};
                        sp_next = sp_reg + 16'd4;
                        pc_next = pc_reg;
                    end
                    smie_pkg::OP_LI: acc_next = rd;
                    smie_pkg::OP_LC: begin
                        acc_next = smie_pkg::sext8(8'(rd >> {acc_reg[1:0], 3'd0}));
                    end
                    smie_pkg::OP_SI: begin
                        we = 1'b1; wbyte = rd; wdata = acc_reg;
                    end
                    smie_pkg::OP_SC: rbyte = rd;
                    smie_pkg::OP_EXIT: begin
                        status_next = smie_pkg::ST_EXITED;
                        exitv_next = rd;
                        pc_next = pc_reg;
                    end
                    smie_pkg::OP_DIV, smie_pkg::OP_MOD: begin
                        if (acc_reg == 32'd0) acc_next = 32'd0;
                        else dreq.start = 1'b1;
                    end
                    default: acc_next = alu_y;
                endcase
            end
            smie_pkg::S_RD2W: begin
                if (op_reg == smie_pkg::OP_LEV) begin
                    pc_next = rd;
                end else begin
                    we = 1'b1; wbyte = tmp_reg;
                    wdata = rd;
                    unique case (tmp_reg[1:0])
                        2'd0: wdata[7:0]   = acc_reg[7:0];
                        2'd1: wdata[15:8]  = acc_reg[7:0];
                        2'd2: wdata[23:16] = acc_reg[7:0];
                        default: wdata[31:24] = acc_reg[7:0];
                    endcase
                    acc_next = smie_pkg::sext8(acc_reg[7:0]);
                end
            end
            smie_pkg::S_DIV: if (drsp.done) begin
                if (op_reg == smie_pkg::OP_DIV)
                    acc_next = (lneg_reg ^ rneg_reg) ? 32'd0 - drsp.quot : drsp.quot;
                else
                    acc_next = lneg_reg ? 32'd0 - drsp.rem : drsp.rem;
            end
            smie_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_in) begin
            op_reg  <= in_op;
        end
        tmp_reg  <= tmp_next;
        lneg_reg <= lneg_next;
        rneg_reg <= rneg_next;
        exitv_reg <= exitv_next;
        status_reg <= status_next;
        rin1_reg <= rin1_next;
        if (!aresetn) begin
            state_reg <= smie_pkg::S_IDLE;
            acc_reg   <= '0;
            pc_reg    <= '0;
            sp_reg    <= '0;
            fp_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            fp_reg    <= fp_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign m_tvalid = (state_reg == smie_pkg::S_DONE);
    assign m_tdata  = {cnt_reg, exitv_reg, acc_reg, pc_reg};
    assign m_tuser  = status_reg;

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.busy |-> (state_reg == smie_pkg::S_DIV)) else $error("divider busy out of step");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != smie_pkg::S_IDLE) |=> (cnt_reg == $past(cnt_reg)))
        else $error("count moved mid-instruction");
`endif
endmodule
`default_nettype wire
